// ===== design/ltok_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltok_pkg
// Shared types and character codes for the line tokenizer.
// ----------------------------------------------------------------------------
package ltok_pkg;

  localparam int CharW = 8;

  localparam logic [CharW-1:0] CH_NUL       = 8'h00;
  localparam logic [CharW-1:0] CH_TAB       = 8'h09;
  localparam logic [CharW-1:0] CH_NEWLINE   = 8'h0A;
  localparam logic [CharW-1:0] CH_CR        = 8'h0D;
  localparam logic [CharW-1:0] CH_SPACE     = 8'h20;
  localparam logic [CharW-1:0] CH_QUOTE     = 8'h22;
  localparam logic [CharW-1:0] CH_SEMICOLON = 8'h3B;
  localparam logic [CharW-1:0] CH_BACKSLASH = 8'h5C;
  localparam logic [CharW-1:0] CH_LOWER_N   = 8'h6E;
  localparam logic [CharW-1:0] CH_LOWER_R   = 8'h72;
  localparam logic [CharW-1:0] CH_LOWER_T   = 8'h74;

  typedef enum logic [2:0] {
    SCAN_BETWEEN = 3'd0,
    SCAN_WORD    = 3'd1,
    SCAN_STRING  = 3'd2,
    SCAN_ESCAPE  = 3'd3,
    SCAN_COMMENT = 3'd4,
    SCAN_SKIP    = 3'd5
  } scan_state_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_UNTERM = 2'd1,
    STATUS_BADESC = 2'd2
  } status_t;

  typedef struct packed {
    logic [CharW-1:0] out_byte;
    logic             byte_valid;
    logic             token_end;
    logic             line_end;
    status_t          status;
  } result_t;

  function automatic logic is_sep(input logic [CharW-1:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE);
  endfunction

endpackage

// ===== design/line_tokenizer_with_quoted_strings.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_tokenizer_with_quoted_strings
// Splits source lines into tokens, one character word in, one result out.
// Path: input register, then result register; the scanner between them is combinational.
// Throughput: 1 character per cycle unless the output stalls; the scanner state updates in one step.
// Reset: synchronous; both stages empty, scanner between tokens at line start.
// ----------------------------------------------------------------------------
module line_tokenizer_with_quoted_strings (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [ltok_pkg::CharW-1:0] s_axis_tdata,   // [7:0] ch
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [ltok_pkg::CharW-1:0] m_axis_tdata,   // [7:0] out_byte
  output logic                       m_axis_tlast,   // line_end
  output logic [3:0]                 m_axis_tuser    // [0] byte_valid, [1] token_end, [3:2] status
);
  import ltok_pkg::*;

  logic             advance;
  logic             ch_valid;
  logic [CharW-1:0] ch;
  result_t          result;

  ltok_in_reg u_in_reg (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .advance       (advance),
    .ch_valid      (ch_valid),
    .ch            (ch)
  );

  ltok_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .ch      (ch),
    .result  (result)
  );

  ltok_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (ch_valid),
    .load          (advance),
    .result        (result),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  a_idle_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  a_error_no_byte: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[3:2] != STATUS_OK) |-> (m_axis_tuser[1:0] == 2'b00))
    else $error("error result carries a byte or token end");

  a_no_byte_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata == CH_NUL))
    else $error("nonzero byte without byte_valid");

  a_line_end_no_byte: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |-> !m_axis_tuser[0])
    else $error("line end carries a token byte");

endmodule

// ===== design/ltok_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltok_in_reg
// Input register: holds one character word until the scanner takes it.
// ----------------------------------------------------------------------------
module ltok_in_reg (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [ltok_pkg::CharW-1:0] s_axis_tdata,   // [7:0] ch
  input  logic                    advance,
  output logic                    ch_valid,
  output logic [ltok_pkg::CharW-1:0] ch
);
  import ltok_pkg::*;

  assign s_axis_tready = !ch_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_valid <= 1'b0;
    end else if (s_axis_tready) begin
      ch_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      ch <= s_axis_tdata;
    end
  end

endmodule

// ===== design/ltok_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltok_scan
// Scanner state and the per-character transition and result logic.
// ----------------------------------------------------------------------------
module ltok_scan (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  logic [ltok_pkg::CharW-1:0] ch,
  output ltok_pkg::result_t          result
);
  import ltok_pkg::*;

  scan_state_t scan_state;
  scan_state_t scan_state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state <= SCAN_BETWEEN;
    end else if (advance) begin
      scan_state <= scan_state_next;
    end
  end

  always_comb begin
    scan_state_next = scan_state;
    case (scan_state)
      SCAN_WORD: begin
        if (ch == CH_NUL || is_sep(ch)) begin
          scan_state_next = SCAN_BETWEEN;
        end else if (ch == CH_SEMICOLON) begin
          scan_state_next = SCAN_COMMENT;
        end
      end
      SCAN_STRING: begin
        if (ch == CH_NUL || ch == CH_QUOTE) begin
          scan_state_next = SCAN_BETWEEN;
        end else if (ch == CH_NEWLINE) begin
          scan_state_next = SCAN_SKIP;
        end else if (ch == CH_BACKSLASH) begin
          scan_state_next = SCAN_ESCAPE;
        end
      end
      SCAN_ESCAPE: begin
        if (ch == CH_NUL) begin
          scan_state_next = SCAN_BETWEEN;
        end else if (ch == CH_LOWER_N || ch == CH_LOWER_R || ch == CH_LOWER_T ||
                     ch == CH_QUOTE || ch == CH_BACKSLASH) begin
          scan_state_next = SCAN_STRING;
        end else begin
          scan_state_next = SCAN_SKIP;
        end
      end
      SCAN_COMMENT, SCAN_SKIP: begin
        if (ch == CH_NUL) begin
          scan_state_next = SCAN_BETWEEN;
        end
      end
      default: begin
        if (ch == CH_NUL || is_sep(ch)) begin
          scan_state_next = SCAN_BETWEEN;
        end else if (ch == CH_SEMICOLON) begin
          scan_state_next = SCAN_COMMENT;
        end else if (ch == CH_QUOTE) begin
          scan_state_next = SCAN_STRING;
        end else begin
          scan_state_next = SCAN_WORD;
        end
      end
    endcase
  end

  always_comb begin
    result          = '0;
    result.status   = STATUS_OK;
    result.line_end = (ch == CH_NUL);
    case (scan_state)
      SCAN_WORD: begin
        if (ch == CH_NUL || is_sep(ch) || ch == CH_SEMICOLON) begin
          result.token_end = 1'b1;
        end else begin
          result.out_byte   = ch;
          result.byte_valid = 1'b1;
        end
      end
      SCAN_STRING: begin
        if (ch == CH_NUL || ch == CH_NEWLINE) begin
          result.status = STATUS_UNTERM;
        end else if (ch == CH_QUOTE) begin
          result.token_end = 1'b1;
        end else if (ch != CH_BACKSLASH) begin
          result.out_byte   = ch;
          result.byte_valid = 1'b1;
        end
      end
      SCAN_ESCAPE: begin
        if (ch == CH_NUL || ch == CH_NEWLINE) begin
          result.status = STATUS_UNTERM;
        end else if (ch == CH_LOWER_N) begin
          result.out_byte   = CH_NEWLINE;
          result.byte_valid = 1'b1;
        end else if (ch == CH_LOWER_R) begin
          result.out_byte   = CH_CR;
          result.byte_valid = 1'b1;
        end else if (ch == CH_LOWER_T) begin
          result.out_byte   = CH_TAB;
          result.byte_valid = 1'b1;
        end else if (ch == CH_QUOTE || ch == CH_BACKSLASH) begin
          result.out_byte   = ch;
          result.byte_valid = 1'b1;
        end else begin
          result.status = STATUS_BADESC;
        end
      end
      SCAN_COMMENT, SCAN_SKIP: begin
      end
      default: begin
        if (ch != CH_NUL && !is_sep(ch) && ch != CH_SEMICOLON && ch != CH_QUOTE) begin
          result.out_byte   = ch;
          result.byte_valid = 1'b1;
        end
      end
    endcase
  end

endmodule

// ===== design/ltok_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ltok_out_reg
// Result register: holds one result word until the consumer takes it.
// ----------------------------------------------------------------------------
module ltok_out_reg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       load,
  input  ltok_pkg::result_t          result,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [ltok_pkg::CharW-1:0] m_axis_tdata,  // [7:0] out_byte
  output logic                       m_axis_tlast,  // line_end
  output logic [3:0]                 m_axis_tuser   // [0] byte_valid, [1] token_end, [3:2] status
);
  import ltok_pkg::*;

  result_t held;

  assign load = in_valid && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (!m_axis_tvalid || m_axis_tready) begin
      m_axis_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

  assign m_axis_tdata = held.out_byte;
  assign m_axis_tlast = held.line_end;
  assign m_axis_tuser = {held.status, held.token_end, held.byte_valid};

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Streams source-line characters into the line tokenizer and checks each
// result word against a cycle-free scanner model kept in the bench. Covers
// plain tokens, strings with every escape, comments, string errors, random
// well-formed and broken lines, line noise, random idling on both sides and
// a long output stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_top;
  import ltok_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  localparam logic [CharW-1:0] SEPS [3] = '{CH_SPACE, CH_TAB, CH_NEWLINE};
  localparam logic [CharW-1:0] ESCS [5] = '{CH_LOWER_N, CH_LOWER_R, CH_LOWER_T,
                                            CH_QUOTE, CH_BACKSLASH};
  localparam logic [CharW-1:0] SPECIALS [10] = '{CH_NUL, CH_TAB, CH_NEWLINE,
                                                 CH_SPACE, CH_QUOTE, CH_SEMICOLON,
                                                 CH_BACKSLASH, CH_LOWER_N,
                                                 CH_LOWER_R, CH_LOWER_T};

  logic             clk = 1'b0;
  logic             rst;
  logic             s_axis_tvalid;
  logic             s_axis_tready;
  logic [CharW-1:0] s_axis_tdata;    // [7:0] ch
  logic             m_axis_tvalid;
  logic             m_axis_tready;
  logic [CharW-1:0] m_axis_tdata;    // [7:0] out_byte
  logic             m_axis_tlast;    // line_end
  logic [3:0]       m_axis_tuser;    // [0] byte_valid, [1] token_end, [3:2] status

  result_t          tok_expect [$];
  logic [CharW-1:0] line_buf [$];
  scan_state_t      scan_st = SCAN_BETWEEN;
  int               src_max = 0;
  int               sink_max = 0;
  int               stall_req = 0;
  int               fail_count = 0;
  int               quiet_cycles = 0;

  line_tokenizer_with_quoted_strings dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic result_t scan_char(input logic [CharW-1:0] c,
                                        inout scan_state_t st);
    result_t r;
    logic    sep;
    r = '0;
    r.status = STATUS_OK;
    sep = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NEWLINE);
    case (st)
      SCAN_WORD: begin
        if (c == CH_NUL) begin
          r.token_end = 1'b1;
          r.line_end = 1'b1;
          st = SCAN_BETWEEN;
        end else if (sep) begin
          r.token_end = 1'b1;
          st = SCAN_BETWEEN;
        end else if (c == CH_SEMICOLON) begin
          r.token_end = 1'b1;
          st = SCAN_COMMENT;
        end else begin
          r.out_byte = c;
          r.byte_valid = 1'b1;
        end
      end
      SCAN_STRING: begin
        if (c == CH_NUL) begin
          r.status = STATUS_UNTERM;
          r.line_end = 1'b1;
          st = SCAN_BETWEEN;
        end else if (c == CH_NEWLINE) begin
          r.status = STATUS_UNTERM;
          st = SCAN_SKIP;
        end else if (c == CH_QUOTE) begin
          r.token_end = 1'b1;
          st = SCAN_BETWEEN;
        end else if (c == CH_BACKSLASH) begin
          st = SCAN_ESCAPE;
        end else begin
          r.out_byte = c;
          r.byte_valid = 1'b1;
        end
      end
      SCAN_ESCAPE: begin
        if (c == CH_NUL) begin
          r.status = STATUS_UNTERM;
          r.line_end = 1'b1;
          st = SCAN_BETWEEN;
        end else if (c == CH_NEWLINE) begin
          r.status = STATUS_UNTERM;
          st = SCAN_SKIP;
        end else if (c == CH_LOWER_N || c == CH_LOWER_R || c == CH_LOWER_T ||
                     c == CH_QUOTE || c == CH_BACKSLASH) begin
          r.out_byte = (c == CH_LOWER_N) ? CH_NEWLINE :
                       (c == CH_LOWER_R) ? CH_CR :
                       (c == CH_LOWER_T) ? CH_TAB : c;
          r.byte_valid = 1'b1;
          st = SCAN_STRING;
        end else begin
          r.status = STATUS_BADESC;
          st = SCAN_SKIP;
        end
      end
      SCAN_COMMENT, SCAN_SKIP: begin
        if (c == CH_NUL) begin
          r.line_end = 1'b1;
          st = SCAN_BETWEEN;
        end
      end
      default: begin
        if (c == CH_NUL) begin
          r.line_end = 1'b1;
          st = SCAN_BETWEEN;
        end else if (sep) begin
          st = SCAN_BETWEEN;
        end else if (c == CH_SEMICOLON) begin
          st = SCAN_COMMENT;
        end else if (c == CH_QUOTE) begin
          st = SCAN_STRING;
        end else begin
          r.out_byte = c;
          r.byte_valid = 1'b1;
          st = SCAN_WORD;
        end
      end
    endcase
    return r;
  endfunction

  function automatic logic [CharW-1:0] plain_char();
    logic [CharW-1:0] c;
    do
      c = CharW'($urandom_range(1, 255));
    while (c == CH_SPACE || c == CH_TAB || c == CH_NEWLINE ||
           c == CH_SEMICOLON || c == CH_QUOTE);
    return c;
  endfunction

  function automatic logic [CharW-1:0] str_char();
    logic [CharW-1:0] c;
    do
      c = CharW'($urandom_range(1, 255));
    while (c == CH_NEWLINE || c == CH_QUOTE || c == CH_BACKSLASH);
    return c;
  endfunction

  task automatic line_add(input logic [CharW-1:0] c);
    line_buf = {line_buf, c};
  endtask

  task automatic send_char(input logic [CharW-1:0] c);
    int      gap;
    result_t exp_word;
    gap = (src_max > 0) ? $urandom_range(0, src_max) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    exp_word = scan_char(c, scan_st);
    tok_expect = {tok_expect, exp_word};
  endtask

  task automatic send_line();
    foreach (line_buf[i]) send_char(line_buf[i]);
    line_buf.delete();
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (tok_expect.size() != 0) @(posedge clk);
  endtask

  task automatic add_tokens(input int n);
    int len;
    for (int i = 0; i < n; i++) begin
      repeat ($urandom_range(i > 0 ? 1 : 0, 2)) line_add(SEPS[$urandom_range(0, 2)]);
      if ($urandom_range(0, 2) == 0) begin
        line_add(CH_QUOTE);
        len = $urandom_range(0, 8);
        for (int j = 0; j < len; j++) begin
          if ($urandom_range(0, 4) == 0) begin
            line_add(CH_BACKSLASH);
            line_add(ESCS[$urandom_range(0, 4)]);
          end else begin
            line_add(str_char());
          end
        end
        line_add(CH_QUOTE);
      end else begin
        len = $urandom_range(1, 8);
        line_add(plain_char());
        for (int j = 1; j < len; j++) begin
          line_add(($urandom_range(0, 7) == 0) ? CH_QUOTE : plain_char());
        end
      end
    end
  endtask

  task automatic test_directed_tokens();
    src_max = 3;
    sink_max = 3;
    line_buf = '{8'hFF, CH_QUOTE, CH_TAB, CH_QUOTE, CH_QUOTE, CH_SPACE, CH_QUOTE,
                 CH_BACKSLASH, CH_LOWER_N, CH_BACKSLASH, CH_LOWER_R,
                 CH_BACKSLASH, CH_LOWER_T, CH_BACKSLASH, CH_QUOTE,
                 CH_BACKSLASH, CH_BACKSLASH, CH_QUOTE, "y", CH_NEWLINE,
                 CH_SEMICOLON, 8'h80, CH_NUL};
    send_line();
    drain_results();
  endtask

  task automatic test_directed_errors();
    src_max = 2;
    sink_max = 5;
    line_buf = '{CH_QUOTE, CH_NUL,
                 CH_QUOTE, CH_BACKSLASH, CH_NUL,
                 CH_QUOTE, CH_NEWLINE, "x", CH_NUL,
                 CH_QUOTE, CH_BACKSLASH, CH_NEWLINE, CH_NUL,
                 CH_QUOTE, CH_BACKSLASH, "q", "x", CH_NUL};
    send_line();
    drain_results();
  endtask

  task automatic test_backpressure();
    src_max = 0;
    sink_max = 0;
    stall_req = 80;
    add_tokens(12);
    line_add(CH_NUL);
    send_line();
    drain_results();
  endtask

  task automatic test_random_lines(input int n_items, input int src_gap, input int sink_gap);
    int               sent;
    int               kind;
    logic [CharW-1:0] c;
    src_max = src_gap;
    sink_max = sink_gap;
    sent = 0;
    while (sent < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        add_tokens($urandom_range(1, 6));
        repeat ($urandom_range(0, 1)) line_add(SEPS[$urandom_range(0, 2)]);
        if ($urandom_range(0, 2) == 0) begin
          line_add(CH_SEMICOLON);
          repeat ($urandom_range(0, 6)) line_add(CharW'($urandom_range(1, 255)));
        end
        line_add(CH_NUL);
      end else if (kind < 85) begin
        add_tokens($urandom_range(0, 3));
        line_add(SEPS[$urandom_range(0, 2)]);
        line_add(CH_QUOTE);
        repeat ($urandom_range(0, 4)) line_add(str_char());
        case ($urandom_range(0, 4))
          0: begin
          end
          1: line_add(CH_NEWLINE);
          2: begin
            line_add(CH_BACKSLASH);
          end
          3: begin
            line_add(CH_BACKSLASH);
            line_add(CH_NEWLINE);
          end
          default: begin
            do
              c = CharW'($urandom_range(1, 255));
            while (c == CH_LOWER_N || c == CH_LOWER_R || c == CH_LOWER_T ||
                   c == CH_QUOTE || c == CH_BACKSLASH || c == CH_NEWLINE);
            line_add(CH_BACKSLASH);
            line_add(c);
          end
        endcase
        repeat ($urandom_range(0, 5)) line_add(CharW'($urandom_range(1, 255)));
        line_add(CH_NUL);
      end else begin
        repeat ($urandom_range(1, 16)) begin
          line_add(($urandom_range(0, 1) == 0) ? SPECIALS[$urandom_range(0, 9)]
                                               : CharW'($urandom_range(0, 255)));
        end
      end
      sent += line_buf.size();
      send_line();
    end
    drain_results();
  endtask

  initial begin : result_sink
    int gap;
    int hold;
    m_axis_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (stall_req > 0) begin
        hold = stall_req;
        stall_req = 0;
        m_axis_tready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      gap = (sink_max > 0) ? $urandom_range(0, sink_max) : 0;
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (m_axis_tvalid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst === 1'b0 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) begin
      if (tok_expect.size() == 0) begin
        $error("unexpected result word: tdata %0h tuser %0h tlast %0b",
               m_axis_tdata, m_axis_tuser, m_axis_tlast);
        fail_count++;
      end else begin
        want = tok_expect.pop_front();
        if (m_axis_tdata !== want.out_byte) begin
          $error("out_byte: expected %0h, got %0h", want.out_byte, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tuser[0] !== want.byte_valid) begin
          $error("byte_valid: expected %0b, got %0b", want.byte_valid, m_axis_tuser[0]);
          fail_count++;
        end
        if (m_axis_tuser[1] !== want.token_end) begin
          $error("token_end: expected %0b, got %0b", want.token_end, m_axis_tuser[1]);
          fail_count++;
        end
        if (m_axis_tlast !== want.line_end) begin
          $error("line_end: expected %0b, got %0b", want.line_end, m_axis_tlast);
          fail_count++;
        end
        if (m_axis_tuser[3:2] !== 2'(want.status)) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser[3:2]);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid === 1'b1 && s_axis_tready === 1'b1) ||
        (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed_tokens();
    test_directed_errors();
    test_backpressure();
    test_random_lines(480, 8, 8);
    test_random_lines(460, 0, 0);
    test_random_lines(460, 8, 0);
    test_random_lines(460, 0, 8);
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
